// ===== sv/lobm_pkg.sv =====
// shared types and constants for the order book matcher
package lobm_pkg;

	localparam int MAX_ORDERS_DEF = 32;
	localparam int ARR_W = 48;

	typedef enum logic [1:0] {
		OP_NEW    = 2'd0,
		OP_AMEND  = 2'd1,
		OP_CANCEL = 2'd2,
		OP_BAD    = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_DUP      = 3'd1,
		ST_NOTFOUND = 3'd2,
		ST_SMALL    = 3'd3,
		ST_INVALID  = 3'd4,
		ST_FULL     = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOOK,
		S_LOOK_END,
		S_CHECK,
		S_SCAN,
		S_SCAN_END,
		S_FILL_RD,
		S_FILL,
		S_REST,
		S_DONE,
		S_OUT
	} state_t;

	// one resting order as stored in the table memory
	typedef struct packed {
		logic [15:0]      ticker;
		logic [31:0]      key;
		logic             side;
		logic [31:0]      price;
		logic [31:0]      total;
		logic [31:0]      filled;
		logic [ARR_W-1:0] arrival;
	} entry_t;

	// one result word
	typedef struct packed {
		logic        last;
		logic [31:0] rest_qty;
		logic [31:0] fill_price;
		logic [31:0] fill_qty;
		logic [31:0] maker_order_id;
		logic [2:0]  status;
		logic        result_kind;
	} result_t;

endpackage

// ===== sv/lobm_table.sv =====
// order table memory with one read port and one write port
module lobm_table
	import lobm_pkg::*;
#(
	parameter int MAX_ORDERS = MAX_ORDERS_DEF,
	parameter int IDX_W = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	output entry_t           rd_data,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  entry_t           wr_data
);

	entry_t mem [MAX_ORDERS];

	// synchronous write
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	// registered read
	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

endmodule

// ===== sv/limit_order_book_matcher.sv =====
// Limit order book matcher: one message (new, amend, cancel) is taken at a time. Resting orders sit
// in a MAX_ORDERS-entry table memory with one read port; every table scan reads one entry per
// cycle. A lookup is one full scan of the table, and each fill takes another scan. Valid bits
// live in flip-flops, cleared by reset. Each result word is held in an output register until
// taken; the next message is accepted after the status word.
module limit_order_book_matcher
	import lobm_pkg::*;
#(
	parameter int MAX_ORDERS = MAX_ORDERS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// opcode[1:0], ticker[17:2], order_id[49:18], side[50], quantity[82:51],
	// price[114:83], zero fill to 120
	input  logic [119:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// status[2:0], maker_order_id[34:3], fill_qty[66:35], fill_price[98:67],
	// rest_qty[130:99], zero fill to 136
	output logic [135:0] m_tdata,
	// result_kind
	output logic         m_tuser,
	output logic         m_tlast
);

	localparam int IDX_W = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ORDERS - 1);

	state_t state_q, state_d;

	// message registers
	opcode_t     op_q;
	logic [15:0] tk_q;
	logic [31:0] key_q;
	logic        side_q;
	logic [31:0] qty_q;
	logic [31:0] price_q;
	logic [31:0] remain_q;
	status_t     st_q;
	logic [31:0] rest_q;

	logic [MAX_ORDERS-1:0] valid_q;
	logic [ARR_W-1:0]      arr_cnt_q;

	// scan control
	logic [IDX_W-1:0] scan_idx_q;
	logic [IDX_W-1:0] rd_idx_s1;
	logic             rd_live_s1;
	logic             found_q;
	logic [IDX_W-1:0] found_idx_q;
	logic             best_ok_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [31:0]      best_price_q;
	logic [ARR_W-1:0] best_arr_q;
	entry_t           ord_q;
	logic             amend_self_q;

	logic             rd_en, wr_en;
	logic [IDX_W-1:0] rd_addr, wr_addr;
	entry_t           rd_data, wr_data;

	result_t res_q;
	logic    out_v_q;

	logic [IDX_W-1:0] free_idx;
	logic             free_ok;

	lobm_table #(.MAX_ORDERS(MAX_ORDERS), .IDX_W(IDX_W)) u_table (
		.clk    (clk),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	// lowest free slot
	always_comb begin
		free_ok = 1'b0;
		free_idx = '0;
		for (int i = MAX_ORDERS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_ok = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
	end

	// candidate checks on the entry read last cycle
	logic match_hit, cross_hit, cand_better;
	logic [31:0] avail, fq;
	always_comb begin
		match_hit = rd_live_s1 && valid_q[rd_idx_s1] && rd_data.ticker == tk_q
			&& rd_data.key == key_q;
		cross_hit = rd_live_s1 && valid_q[rd_idx_s1] && rd_data.ticker == tk_q
			&& rd_data.side != side_q
			&& (side_q ? (price_q <= rd_data.price) : (price_q >= rd_data.price));
		if (!best_ok_q)
			cand_better = 1'b1;
		else if (rd_data.price != best_price_q)
			cand_better = side_q ? (rd_data.price > best_price_q)
				: (rd_data.price < best_price_q);
		else
			cand_better = rd_data.arrival < best_arr_q;
		avail = rd_data.total - rd_data.filled;
		fq = (avail < remain_q) ? avail : remain_q;
	end

	logic in_bad;
	assign in_bad = s_tdata[1:0] == OP_BAD || s_tdata[82:51] == '0 || s_tdata[114:83] == '0;
	assign s_tready = state_q == S_IDLE;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:     if (s_tvalid) state_d = in_bad ? S_DONE : S_LOOK;
			S_LOOK:     if (scan_idx_q == LAST_IDX) state_d = S_LOOK_END;
			S_LOOK_END: state_d = S_CHECK;
			S_CHECK: begin
				if (op_q == OP_NEW)
					state_d = found_q ? S_DONE : S_SCAN;
				else if (!found_q || op_q == OP_CANCEL || qty_q <= ord_q.filled)
					state_d = S_DONE;
				else
					state_d = (price_q == ord_q.price) ? S_REST : S_SCAN;
			end
			S_SCAN:     if (scan_idx_q == LAST_IDX) state_d = S_SCAN_END;
			S_SCAN_END: state_d = S_FILL_RD;
			S_FILL_RD:  state_d = best_ok_q ? S_FILL : S_REST;
			S_FILL:     if (!out_v_q) state_d = (remain_q == fq) ? S_REST : S_SCAN;
			S_REST:     state_d = S_DONE;
			S_DONE:     if (!out_v_q) state_d = S_OUT;
			S_OUT:      if (!out_v_q) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		rd_en = 1'b0;
		rd_addr = scan_idx_q;
		wr_en = 1'b0;
		wr_addr = best_idx_q;
		wr_data = rd_data;
		unique case (state_q)
			S_LOOK, S_SCAN: rd_en = 1'b1;
			S_FILL_RD: begin
				rd_en = best_ok_q;
				rd_addr = best_idx_q;
			end
			S_FILL: begin
				wr_en = !out_v_q;
				wr_data.filled = rd_data.filled + fq;
			end
			S_REST: begin
				wr_addr = (op_q == OP_NEW) ? free_idx : found_idx_q;
				wr_data = ord_q;
				wr_data.filled = qty_q - remain_q;
				wr_en = (op_q == OP_NEW) ? (remain_q != '0 && free_ok)
					: (op_q == OP_AMEND && amend_self_q);
			end
			default: ;
		endcase
	end

	// datapath and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			arr_cnt_q <= '0;
			out_v_q <= 1'b0;
			rd_live_s1 <= 1'b0;
			scan_idx_q <= '0;
			found_q <= 1'b0;
			best_ok_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_live_s1 <= (state_q == S_LOOK || state_q == S_SCAN);
			rd_idx_s1 <= scan_idx_q;
			if (out_v_q && m_tready)
				out_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (s_tvalid) begin
					op_q <= opcode_t'(s_tdata[1:0]);
					tk_q <= s_tdata[17:2];
					key_q <= s_tdata[49:18];
					side_q <= s_tdata[50];
					qty_q <= s_tdata[82:51];
					price_q <= s_tdata[114:83];
					st_q <= in_bad ? ST_INVALID : ST_OK;
					rest_q <= '0;
					scan_idx_q <= '0;
					found_q <= 1'b0;
					amend_self_q <= 1'b0;
				end
				S_LOOK: scan_idx_q <= scan_idx_q + 1'b1;
				S_LOOK_END, S_SCAN_END: begin
					if (match_hit && state_q == S_LOOK_END) begin
						found_q <= 1'b1;
						found_idx_q <= rd_idx_s1;
						ord_q <= rd_data;
					end
					if (cross_hit && cand_better && state_q == S_SCAN_END) begin
						best_ok_q <= 1'b1;
						best_idx_q <= rd_idx_s1;
						best_price_q <= rd_data.price;
						best_arr_q <= rd_data.arrival;
					end
					scan_idx_q <= '0;
				end
				S_CHECK: begin
					best_ok_q <= 1'b0;
					remain_q <= (op_q == OP_AMEND) ? qty_q - ord_q.filled : qty_q;
					ord_q.ticker <= tk_q;
					ord_q.key <= key_q;
					ord_q.price <= price_q;
					ord_q.total <= qty_q;
					ord_q.arrival <= arr_cnt_q;
					if (op_q == OP_NEW) begin
						ord_q.side <= side_q;
						if (found_q)
							st_q <= ST_DUP;
					end else if (!found_q) begin
						st_q <= ST_NOTFOUND;
					end else if (op_q == OP_CANCEL) begin
						valid_q[found_idx_q] <= 1'b0;
					end else if (qty_q <= ord_q.filled) begin
						st_q <= ST_SMALL;
					end else begin
						// amend: new total and arrival; rematch only on price change
						amend_self_q <= 1'b1;
						side_q <= ord_q.side;
						arr_cnt_q <= arr_cnt_q + 1'b1;
						valid_q[found_idx_q] <= 1'b0;
					end
				end
				S_SCAN: scan_idx_q <= scan_idx_q + 1'b1;
				S_FILL: if (!out_v_q) begin
					remain_q <= remain_q - fq;
					if (rd_data.filled + fq >= rd_data.total)
						valid_q[best_idx_q] <= 1'b0;
					best_ok_q <= 1'b0;
					res_q <= '{last: 1'b0, rest_qty: '0, fill_price: rd_data.price,
						fill_qty: fq, maker_order_id: rd_data.key, status: ST_OK,
						result_kind: 1'b0};
					out_v_q <= 1'b1;
				end
				S_REST: begin
					if (op_q == OP_NEW) begin
						if (remain_q != '0) begin
							if (free_ok) begin
								valid_q[free_idx] <= 1'b1;
								arr_cnt_q <= arr_cnt_q + 1'b1;
								rest_q <= remain_q;
							end else
								st_q <= ST_FULL;
						end
					end else if (remain_q != '0) begin
						valid_q[found_idx_q] <= 1'b1;
						rest_q <= remain_q;
					end
				end
				S_DONE: if (!out_v_q) begin
					res_q <= '{last: 1'b1, rest_qty: rest_q, fill_price: '0, fill_qty: '0,
						maker_order_id: '0, status: st_q, result_kind: 1'b1};
					out_v_q <= 1'b1;
				end
				default: ;
			endcase
			// scan candidates stream in during the scan
			if (state_q == S_LOOK && match_hit) begin
				found_q <= 1'b1;
				found_idx_q <= rd_idx_s1;
				ord_q <= rd_data;
			end
			if (state_q == S_SCAN && cross_hit && cand_better) begin
				best_ok_q <= 1'b1;
				best_idx_q <= rd_idx_s1;
				best_price_q <= rd_data.price;
				best_arr_q <= rd_data.arrival;
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser = res_q.result_kind;
	assign m_tlast = res_q.last;
	assign m_tdata = {5'd0, res_q.rest_qty, res_q.fill_price, res_q.fill_qty,
		res_q.maker_order_id, res_q.status};

	// a fill word never carries last
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> !m_tlast) else $error("fill word flagged last");
	// no input taken while a message is in progress
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> state_q == S_IDLE) else $error("ready outside idle");
	// the table write port never fires during a scan
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN || state_q == S_LOOK) |-> !wr_en) else $error("write in scan");

endmodule
